@@ src/osts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osts_pkg
// Shared types and codes for the one-shot timer slot table.
// ----------------------------------------------------------------------------
package osts_pkg;

    localparam int DEFAULT_SLOT_COUNT = 8;

    localparam logic [1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [1:0] MODE_TICK     = 2'd1;
    localparam logic [1:0] MODE_CANCEL   = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam int SLOT_FIELD_W = 3;

    typedef struct packed {
        logic [1:0]              mode;
        logic [30:0]             delay;
        logic [7:0]              handler_id;
        logic [31:0]             param_value;
        logic [31:0]             now_time;
        logic [SLOT_FIELD_W-1:0] slot_index;
    } req_item_t;

    typedef struct packed {
        logic                    kind;
        logic                    status;
        logic [SLOT_FIELD_W-1:0] fired_slot;
        logic [7:0]              fired_handler;
        logic [31:0]             fired_param;
        logic                    last;
    } rsp_item_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [7:0]  handler;
        logic [31:0] param;
    } slot_entry_t;

endpackage

@@ src/osts_slot_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osts_slot_mem
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module osts_slot_mem #(
    parameter int DEPTH  = osts_pkg::DEFAULT_SLOT_COUNT,
    parameter int ADDR_W = 3
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  osts_pkg::slot_entry_t wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output osts_pkg::slot_entry_t rd_data
);

    osts_pkg::slot_entry_t mem [DEPTH];
    osts_pkg::slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/osts_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osts_ctrl
// Sequencer: armed bits, free-slot search, tick scan and result register.
// ----------------------------------------------------------------------------
module osts_ctrl #(
    parameter int SLOT_COUNT = osts_pkg::DEFAULT_SLOT_COUNT,
    parameter int IDX_W      = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  osts_pkg::req_item_t   req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output osts_pkg::rsp_item_t   rsp,
    output logic                  mem_we,
    output logic [IDX_W-1:0]      mem_waddr,
    output osts_pkg::slot_entry_t mem_wdata,
    output logic                  mem_re,
    output logic [IDX_W-1:0]      mem_raddr,
    input  osts_pkg::slot_entry_t mem_rdata
);

    localparam int SLOT_W = osts_pkg::SLOT_FIELD_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCHED = 5'b00010,
        ST_READ  = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [SLOT_COUNT-1:0]   armed_reg, armed_next;
    logic [31:0]             last_time_reg, last_time_next;
    logic                    pend_valid_reg, pend_valid_next;
    osts_pkg::rsp_item_t     pend_reg, pend_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    osts_pkg::rsp_item_t     rsp_data_reg, rsp_data_next;
    osts_pkg::req_item_t     cmd_reg, cmd_next;

    logic                    out_free;
    logic                    free_found;
    logic [IDX_W-1:0]        free_idx;
    logic [31:0]             deadline_sum;
    logic                    fire;
    logic                    stall;
    logic                    cancel_hit;
    logic [IDX_W-1:0]        cancel_idx;

    assign req_ready    = (state_reg == ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_data_reg;
    assign out_free     = !rsp_valid_reg || rsp_ready;
    assign deadline_sum = last_time_reg + {1'b0, cmd_reg.delay};
    assign fire         = armed_reg[idx_reg] && (cmd_reg.now_time > mem_rdata.deadline);
    assign stall        = fire && pend_valid_reg && !out_free;
    assign cancel_hit   = (int'(req.slot_index) < SLOT_COUNT);
    assign cancel_idx   = IDX_W'(req.slot_index);

    // Pick the lowest-numbered free slot.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!armed_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        armed_next      = armed_reg;
        last_time_next  = last_time_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_data_next   = rsp_data_reg;
        cmd_next        = cmd_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;
        mem_wdata       = '{deadline: deadline_sum,
                            handler:  cmd_reg.handler_id,
                            param:    cmd_reg.param_value};
        mem_re          = 1'b0;
        mem_raddr       = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req;
                    priority if (req.mode == osts_pkg::MODE_SCHEDULE)
                    begin
                        state_next = ST_SCHED;
                    end
                    else if (req.mode == osts_pkg::MODE_TICK)
                    begin
                        last_time_next = req.now_time;
                        idx_next       = '0;
                        state_next     = ST_READ;
                    end
                    else if (req.mode == osts_pkg::MODE_CANCEL)
                    begin
                        if (cancel_hit)
                        begin
                            armed_next[cancel_idx] = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCHED:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = '{kind:          osts_pkg::KIND_STATUS,
                                       status:        free_found,
                                       fired_slot:    '0,
                                       fired_handler: '0,
                                       fired_param:   '0,
                                       last:          1'b1};
                    if (free_found)
                    begin
                        mem_we               = 1'b1;
                        armed_next[free_idx] = (deadline_sum != 32'd0);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!stall)
                begin
                    if (fire)
                    begin
                        armed_next[idx_reg] = 1'b0;
                        pend_valid_next     = 1'b1;
                        pend_next           = '{kind:          osts_pkg::KIND_EXPIRY,
                                                status:        1'b0,
                                                fired_slot:    SLOT_W'(idx_reg),
                                                fired_handler: mem_rdata.handler,
                                                fired_param:   mem_rdata.param,
                                                last:          1'b0};
                        if (pend_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_data_next  = pend_reg;
                        end
                    end
                    if (idx_reg == IDX_W'(SLOT_COUNT - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_data_next      = pend_reg;
                    rsp_data_next.last = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            armed_reg      <= '0;
            last_time_reg  <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            armed_reg      <= armed_next;
            last_time_reg  <= last_time_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        rsp_data_reg <= rsp_data_next;
        cmd_reg      <= cmd_next;
    end

`ifndef SYNTH
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !pend_valid_reg)
        else $error("expiry still held while accepting transactions");

    a_sched_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.mode == osts_pkg::MODE_SCHEDULE)
        |=> state_reg == ST_SCHED)
        else $error("schedule transaction did not start");

    a_sched_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCHED && out_free)
        |=> rsp_valid_reg && rsp_data_reg.last
            && rsp_data_reg.kind == osts_pkg::KIND_STATUS)
        else $error("schedule status not presented");

    a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && fire && !stall) |=> !armed_reg[$past(idx_reg)])
        else $error("fired slot still armed");

    a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.mode == osts_pkg::MODE_TICK)
        |=> last_time_reg == $past(req.now_time))
        else $error("tick time not recorded");
`endif

endmodule

@@ src/one_shot_timer_slot_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_slot_table_unit
// Table of one-shot timer slots with schedule, tick and cancel requests.
// ----------------------------------------------------------------------------
// Usage:
//   req channel takes one request per transaction: schedule, tick or cancel.
//   rsp channel returns results: one status for a schedule, one expiry per
//   fired slot for a tick (last set on the final one), none for a cancel.
//   A request is taken only while the sequencer is idle.
// Sequence:
//   schedule: status computed in the schedule state once the output
//     register is free; next request taken once back in idle.
//   tick: each slot gets a memory read state, then a compare state; the
//     scan moves on unless a firing slot stalls on full results.
//   cancel: handled in the idle state alone.
// Reset: clears all armed bits and the last tick time; the slot memory is
//   not cleared and needs no clearing pass.
// Stall: results wait in an output register plus one held expiry; the scan
//   holds on a firing slot while both are full.
// ----------------------------------------------------------------------------
module one_shot_timer_slot_table_unit #(
    parameter int SLOT_COUNT = osts_pkg::DEFAULT_SLOT_COUNT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  osts_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output osts_pkg::rsp_item_t rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    osts_pkg::slot_entry_t mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    osts_pkg::slot_entry_t mem_rdata;

    osts_slot_mem #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    osts_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule
